FILE: design/gcph_pkg.sv
// Shared types and constants for the grid cell point histogram.
package gcph_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned SPAN_W     = COORD_W + 1;
  localparam int unsigned CELLS_W    = 7;
  localparam int unsigned CELL_IDX_W = 6;
  localparam int unsigned OUT_CNT_W  = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEST  = 3'd0,
    CFG_EAST  = 3'd1,
    CFG_NORTH = 3'd2,
    CFG_SOUTH = 3'd3,
    CFG_WIDE  = 3'd4,
    CFG_HIGH  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                     start;
    logic signed [SPAN_W-1:0] offset;
    logic signed [SPAN_W-1:0] span;
    logic [CELLS_W-1:0]       cells;
  } bin_req_t;

  typedef struct packed {
    logic               done;
    logic [CELLS_W-1:0] index;
  } bin_rsp_t;

endpackage

FILE: design/gcph_if.sv
// Valid/ready channel interfaces for point items and histogram results.
interface gcph_item_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic                                is_adult;
  logic signed [gcph_pkg::COORD_W-1:0] point_lon;
  logic signed [gcph_pkg::COORD_W-1:0] point_lat;

  modport source (output valid, command, is_adult, point_lon, point_lat, input ready);
  modport sink   (input valid, command, is_adult, point_lon, point_lat, output ready);
endinterface

interface gcph_result_if;
  logic                                valid;
  logic                                ready;
  logic [gcph_pkg::CELL_IDX_W-1:0]     cell_row;
  logic [gcph_pkg::CELL_IDX_W-1:0]     cell_col;
  logic [gcph_pkg::OUT_CNT_W-1:0]      point_count;
  logic                                scan_done;

  modport source (output valid, cell_row, cell_col, point_count, scan_done, input ready);
  modport sink   (input valid, cell_row, cell_col, point_count, scan_done, output ready);
endinterface

FILE: design/gcph_ram.sv
// Generic simple dual-port RAM with registered read.
module gcph_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/gcph_bin.sv
// Iterative bin index unit: offset*cells/span, truncated and clamped, one bit per step.
module gcph_bin (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gcph_pkg::bin_req_t  req_i,
  output gcph_pkg::bin_rsp_t  rsp_o
);
  import gcph_pkg::*;

  localparam int unsigned NUM_W = SPAN_W + CELLS_W;
  localparam int unsigned K_W   = $clog2(CELLS_W);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_CMP  = 5'b00010,
    B_MUL  = 5'b00100,
    B_DIV  = 5'b01000,
    B_DONE = 5'b10000
  } b_state_e;

  b_state_e           state_q, state_d;
  logic [SPAN_W-1:0]  a_q, a_d, b_q, b_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [CELLS_W-1:0] q_q, q_d, cells_q, cells_d;
  logic [K_W-1:0]     k_q, k_d;

  logic [NUM_W:0]     sub_x, sub_y, diff;
  logic               fits;
  logic               trivial;
  logic [SPAN_W-1:0]  off_mag, span_mag;

  // shared compare/subtract unit
  always_comb begin
    sub_x = {1'b0, NUM_W'(a_q)};
    sub_y = {1'b0, NUM_W'(b_q)};
    if (state_q == B_DIV) begin
      sub_x = {1'b0, num_q};
      sub_y = {1'b0, NUM_W'(b_q) << k_q};
    end
  end
  assign diff = sub_x - sub_y;
  assign fits = ~diff[NUM_W];

  assign trivial  = (req_i.span == '0) || (req_i.offset == '0) ||
                    (req_i.offset[SPAN_W-1] != req_i.span[SPAN_W-1]);
  assign off_mag  = req_i.offset[SPAN_W-1] ? SPAN_W'(-req_i.offset) : SPAN_W'(req_i.offset);
  assign span_mag = req_i.span[SPAN_W-1] ? SPAN_W'(-req_i.span) : SPAN_W'(req_i.span);

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    num_d   = num_q;
    q_d     = q_q;
    cells_d = cells_q;
    k_d     = k_q;
    unique case (state_q)
      B_IDLE, B_DONE: begin
        state_d = B_IDLE;
        if (req_i.start) begin
          cells_d = req_i.cells;
          a_d     = off_mag;
          b_d     = span_mag;
          q_d     = '0;
          state_d = trivial ? B_DONE : B_CMP;
        end
      end
      B_CMP: begin
        if (fits) begin
          q_d     = cells_q - CELLS_W'(1);
          state_d = B_DONE;
        end else begin
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        num_d   = a_q * cells_q;
        k_d     = K_W'(CELLS_W - 1);
        state_d = B_DIV;
      end
      B_DIV: begin
        if (fits) begin
          num_d    = diff[NUM_W-1:0];
          q_d[k_q] = 1'b1;
        end
        if (k_q == '0) begin
          state_d = B_DONE;
        end else begin
          k_d = k_q - K_W'(1);
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    num_q   <= num_d;
    q_q     <= q_d;
    cells_q <= cells_d;
    k_q     <= k_d;
  end

  assign rsp_o.done  = (state_q == B_DONE);
  assign rsp_o.index = q_q;

  a_done_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DONE) |-> (q_q < cells_q))
    else $error("bin index not below cell count");

endmodule

FILE: design/grid_cell_point_histogram.sv
// Two-dimensional point histogram: bins points into a grid and reads out nonzero cells.
//
// Items arrive on item_i (valid/ready). command 0 adds a point: if is_adult is set,
// its column and row are found by two runs of a shared bit-serial divider (a zero
// span, a zero offset, opposite signs or a point at or past the far edge skip the
// division) and the cell count in the count RAM is incremented with saturation; an
// adult add keeps the block busy after its transfer, another add does not, and no
// add gives a result. command 1 reads: the scan walks the count RAM from its cursor,
// reading each entry in ST_SCAN_RD and checking it in ST_SCAN_CHK (one RAM read
// port), reports the first nonzero cell on result_o and clears it, or reports
// scan_done and rewinds. One item is in work at a time; item_i.ready is high only
// between items.
// The result sits in an output register; a new item is taken while it waits, and
// a later read holds its result until the receiver takes the earlier one.
// After reset the count RAM is zeroed, one entry per cycle, before the first item is
// taken; configuration writes on cfg_we_i/cfg_index_i/cfg_wdata_i are taken at any
// time and must be made only while no item is in work.
module grid_cell_point_histogram #(
  parameter int unsigned MAX_GRID_COLS = 64,
  parameter int unsigned MAX_GRID_ROWS = 64,
  parameter int unsigned COUNT_BITS    = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gcph_item_if.sink                       item_i,
  gcph_result_if.source                   result_o,
  input  logic                            cfg_we_i,
  input  logic [gcph_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gcph_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import gcph_pkg::*;

  localparam int unsigned DEPTH = MAX_GRID_ROWS * MAX_GRID_COLS;
  localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned RW    = MAX_GRID_ROWS > 1 ? $clog2(MAX_GRID_ROWS) : 1;
  localparam int unsigned CW    = MAX_GRID_COLS > 1 ? $clog2(MAX_GRID_COLS) : 1;

  typedef enum logic [8:0] {
    ST_CLEAR    = 9'b000000001,
    ST_IDLE     = 9'b000000010,
    ST_COL      = 9'b000000100,
    ST_ROW      = 9'b000001000,
    ST_ADD_RD   = 9'b000010000,
    ST_ADD_UPD  = 9'b000100000,
    ST_SCAN_RD  = 9'b001000000,
    ST_SCAN_CHK = 9'b010000000,
    ST_EMIT     = 9'b100000000
  } state_e;

  function automatic logic [CELLS_W-1:0] limit_cells(input logic [CELLS_W-1:0] n,
                                                    input int unsigned maxv);
    logic [CELLS_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = CELLS_W'(1);
    end else if (int'(n) > int'(maxv)) begin
      r = CELLS_W'(maxv);
    end
    return r;
  endfunction

  // configuration registers
  logic signed [COORD_W-1:0] west_q, east_q, north_q, south_q;
  logic [CELLS_W-1:0]        wide_q, high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      west_q  <= '0;
      east_q  <= '0;
      north_q <= '0;
      south_q <= '0;
      wide_q  <= CELLS_W'(1);
      high_q  <= CELLS_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WEST:  west_q  <= cfg_wdata_i;
        CFG_EAST:  east_q  <= cfg_wdata_i;
        CFG_NORTH: north_q <= cfg_wdata_i;
        CFG_SOUTH: south_q <= cfg_wdata_i;
        CFG_WIDE:  wide_q  <= cfg_wdata_i[CELLS_W-1:0];
        CFG_HIGH:  high_q  <= cfg_wdata_i[CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  state_e                    state_q, state_d;
  logic [RW-1:0]             cur_row_q, cur_row_d;
  logic [CW-1:0]             cur_col_q, cur_col_d;
  logic [RW-1:0]             bin_row_q, bin_row_d;
  logic [CW-1:0]             bin_col_q, bin_col_d;
  logic signed [COORD_W-1:0] lat_q, lat_d;
  logic [CELL_IDX_W-1:0]     res_row_q, res_row_d, res_col_q, res_col_d;
  logic [OUT_CNT_W-1:0]      res_cnt_q, res_cnt_d;
  logic                      res_done_q, res_done_d;
  logic                      out_valid_q, out_valid_d;
  logic [CELL_IDX_W-1:0]     out_row_q, out_row_d, out_col_q, out_col_d;
  logic [OUT_CNT_W-1:0]      out_cnt_q, out_cnt_d;
  logic                      out_done_q, out_done_d;

  bin_req_t                  bin_req;
  bin_rsp_t                  bin_rsp;
  logic                      accept;
  logic [CELLS_W-1:0]        w_lim, h_lim;
  logic signed [SPAN_W-1:0]  west_x, east_x, north_x, south_x, lon_x, lat_x;

  logic                      use_bin_addr;
  logic [AW-1:0]             ram_addr;
  logic                      ram_we, ram_re;
  logic [COUNT_BITS-1:0]     ram_wdata, ram_rdata;
  logic [63:0]               cnt_wide;
  logic                      cur_last;
  logic [RW-1:0]             adv_row;
  logic [CW-1:0]             adv_col;

  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;

  assign w_lim   = limit_cells(wide_q, MAX_GRID_COLS);
  assign h_lim   = limit_cells(high_q, MAX_GRID_ROWS);
  assign west_x  = SPAN_W'(west_q);
  assign east_x  = SPAN_W'(east_q);
  assign north_x = SPAN_W'(north_q);
  assign south_x = SPAN_W'(south_q);
  assign lon_x   = SPAN_W'(item_i.point_lon);
  assign lat_x   = SPAN_W'(lat_q);

  always_comb begin
    bin_req.start  = accept && (cmd_e'(item_i.command) == CMD_ADD) && item_i.is_adult;
    bin_req.offset = lon_x - west_x;
    bin_req.span   = east_x - west_x;
    bin_req.cells  = w_lim;
    if (state_q == ST_COL) begin
      bin_req.start  = bin_rsp.done;
      bin_req.offset = north_x - lat_x;
      bin_req.span   = north_x - south_x;
      bin_req.cells  = h_lim;
    end
  end

  gcph_bin u_bin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (bin_req),
    .rsp_o  (bin_rsp)
  );

  // row-major cursor stepping with wrap
  assign cur_last = (cur_row_q == RW'(MAX_GRID_ROWS - 1)) &&
                    (cur_col_q == CW'(MAX_GRID_COLS - 1));
  always_comb begin
    adv_row = cur_row_q;
    adv_col = cur_col_q + CW'(1);
    if (cur_col_q == CW'(MAX_GRID_COLS - 1)) begin
      adv_col = '0;
      adv_row = (cur_row_q == RW'(MAX_GRID_ROWS - 1)) ? '0 : cur_row_q + RW'(1);
    end
  end

  assign use_bin_addr = (state_q == ST_ADD_RD) || (state_q == ST_ADD_UPD);
  assign ram_addr = use_bin_addr ?
                    AW'(AW'(bin_row_q) * AW'(MAX_GRID_COLS)) + AW'(bin_col_q) :
                    AW'(AW'(cur_row_q) * AW'(MAX_GRID_COLS)) + AW'(cur_col_q);
  assign cnt_wide = 64'(ram_rdata);

  gcph_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cur_row_d   = cur_row_q;
    cur_col_d   = cur_col_q;
    bin_row_d   = bin_row_q;
    bin_col_d   = bin_col_q;
    lat_d       = lat_q;
    res_row_d   = res_row_q;
    res_col_d   = res_col_q;
    res_cnt_d   = res_cnt_q;
    res_done_d  = res_done_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_cnt_d   = out_cnt_q;
    out_done_d  = out_done_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        cur_row_d = adv_row;
        cur_col_d = adv_col;
        if (cur_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          lat_d = item_i.point_lat;
          if (cmd_e'(item_i.command) == CMD_READ) begin
            state_d = ST_SCAN_RD;
          end else if (item_i.is_adult) begin
            state_d = ST_COL;
          end
        end
      end
      ST_COL: begin
        if (bin_rsp.done) begin
          bin_col_d = CW'(bin_rsp.index);
          state_d   = ST_ROW;
        end
      end
      ST_ROW: begin
        if (bin_rsp.done) begin
          bin_row_d = RW'(bin_rsp.index);
          state_d   = ST_ADD_RD;
        end
      end
      ST_ADD_RD: begin
        ram_re  = 1'b1;
        state_d = ST_ADD_UPD;
      end
      ST_ADD_UPD: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
        state_d   = ST_IDLE;
      end
      ST_SCAN_RD: begin
        ram_re  = 1'b1;
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        cur_row_d = adv_row;
        cur_col_d = adv_col;
        if (ram_rdata != '0) begin
          ram_we     = 1'b1;
          res_row_d  = CELL_IDX_W'(cur_row_q);
          res_col_d  = CELL_IDX_W'(cur_col_q);
          res_cnt_d  = (cnt_wide[63:32] != '0) ? '1 : cnt_wide[31:0];
          res_done_d = 1'b0;
          state_d    = ST_EMIT;
        end else if (cur_last) begin
          res_row_d  = '0;
          res_col_d  = '0;
          res_cnt_d  = '0;
          res_done_d = 1'b1;
          state_d    = ST_EMIT;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_row_d   = res_row_q;
          out_col_d   = res_col_q;
          out_cnt_d   = res_cnt_q;
          out_done_d  = res_done_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_row_q  <= bin_row_d;
    bin_col_q  <= bin_col_d;
    lat_q      <= lat_d;
    res_row_q  <= res_row_d;
    res_col_q  <= res_col_d;
    res_cnt_q  <= res_cnt_d;
    res_done_q <= res_done_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_cnt_q  <= out_cnt_d;
    out_done_q <= out_done_d;
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.cell_row    = out_row_q;
  assign result_o.cell_col    = out_col_q;
  assign result_o.point_count = out_cnt_q;
  assign result_o.scan_done   = out_done_q;

  a_done_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |->
      (out_row_q == '0) && (out_col_q == '0) && (out_cnt_q == '0))
    else $error("scan_done transfer with nonzero cell fields");

  a_cell_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_done_q) |-> (out_cnt_q != '0))
    else $error("reported cell has zero count");

  a_bin_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_rsp.done |-> (state_q == ST_COL) || (state_q == ST_ROW))
    else $error("bin result arrived outside an add");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the grid cell point histogram: directed table, then random phases.
module tb_top;
  import gcph_pkg::*;

  localparam int unsigned GRID_COLS     = 64;
  localparam int unsigned GRID_ROWS     = 64;
  localparam int unsigned STORE_DEPTH   = GRID_COLS * GRID_ROWS;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STALL_LIMIT   = 40000;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_ITEMS   = 34;

  typedef struct packed {
    logic [CELL_IDX_W-1:0] row;
    logic [CELL_IDX_W-1:0] col;
    logic [OUT_CNT_W-1:0]  count;
    logic                  done;
  } cell_report_t;

  typedef enum {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e       kind;
    cmd_e            cmd;
    bit              adult;
    int              lon;
    int              lat;
    cfg_idx_e        reg_idx;
    logic [31:0]     reg_val;
    bit              typed;
    cell_report_t    rep;
  } script_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  gcph_item_if   item_bus ();
  gcph_result_if result_bus ();

  grid_cell_point_histogram u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_bus),
    .result_o    (result_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // histogram predictor state
  logic [31:0]  tally [STORE_DEPTH];
  int unsigned  scan_ptr;
  int           m_west, m_east, m_north, m_south;
  logic [6:0]   m_wide, m_high;

  cell_report_t pending_cells [$];
  int unsigned  mismatches;
  int unsigned  quiet_cycles;
  bit           src_calm, sink_calm;

  function automatic int unsigned grid_cells(logic [6:0] n, int unsigned maxv);
    if (n == 0) return 1;
    if (n > maxv) return maxv;
    return n;
  endfunction

  function automatic int unsigned bin_of(longint offset, longint span, int unsigned cells);
    longint q;
    if (span == 0) return 0;
    q = (offset * longint'(cells)) / span;
    if (q < 0) q = 0;
    if (q >= longint'(cells)) q = longint'(cells) - 1;
    return int'(q);
  endfunction

  function automatic void grid_write(cfg_idx_e idx, logic [31:0] val);
    case (idx)
      CFG_WEST:  m_west  = int'(val);
      CFG_EAST:  m_east  = int'(val);
      CFG_NORTH: m_north = int'(val);
      CFG_SOUTH: m_south = int'(val);
      CFG_WIDE:  m_wide  = val[6:0];
      CFG_HIGH:  m_high  = val[6:0];
      default: ;
    endcase
  endfunction

  // returns 1 when the item yields a report
  function automatic bit histogram_step(cmd_e cmd, bit adult, int lon, int lat,
                                        output cell_report_t rep);
    int unsigned col, row, idx, i;
    rep = '0;
    if (cmd == CMD_ADD) begin
      if (!adult) return 0;
      col = bin_of(longint'(lon) - longint'(m_west), longint'(m_east) - longint'(m_west),
                   grid_cells(m_wide, GRID_COLS));
      row = bin_of(longint'(m_north) - longint'(lat), longint'(m_north) - longint'(m_south),
                   grid_cells(m_high, GRID_ROWS));
      idx = row * GRID_COLS + col;
      if (tally[idx] != '1) tally[idx] = tally[idx] + 1;
      return 0;
    end
    i = scan_ptr;
    while (i < STORE_DEPTH && tally[i] == 0) i++;
    if (i >= STORE_DEPTH) begin
      scan_ptr = 0;
      rep.done = 1'b1;
    end else begin
      rep.row   = CELL_IDX_W'(i / GRID_COLS);
      rep.col   = CELL_IDX_W'(i % GRID_COLS);
      rep.count = tally[i];
      tally[i]  = '0;
      scan_ptr  = (i + 1 >= STORE_DEPTH) ? 0 : i + 1;
    end
    return 1;
  endfunction

  function automatic script_row_t point_row(cmd_e cmd, bit adult, int lon, int lat,
                                            bit typed = 1'b0, cell_report_t rep = '0);
    script_row_t r;
    r.kind    = ROW_ITEM;
    r.cmd     = cmd;
    r.adult   = adult;
    r.lon     = lon;
    r.lat     = lat;
    r.reg_idx = CFG_WEST;
    r.reg_val = '0;
    r.typed   = typed;
    r.rep     = rep;
    return r;
  endfunction

  function automatic script_row_t reg_row(cfg_idx_e idx, logic [31:0] val);
    script_row_t r;
    r         = point_row(CMD_ADD, 1'b0, 0, 0);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic await_drain();
    @(negedge clk_i);
    item_bus.valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    await_drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    grid_write(idx, val);
  endtask

  task automatic send_point(cmd_e cmd, bit adult, int lon, int lat,
                            bit typed = 1'b0, cell_report_t typed_rep = '0);
    int unsigned  gap;
    cell_report_t rep;
    gap = src_calm ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_bus.valid     <= 1'b1;
    item_bus.command   <= cmd;
    item_bus.is_adult  <= adult;
    item_bus.point_lon <= lon;
    item_bus.point_lat <= lat;
    do @(posedge clk_i); while (!(item_bus.valid === 1'b1 && item_bus.ready === 1'b1));
    if (histogram_step(cmd, adult, lon, lat, rep))
      pending_cells = {pending_cells, (typed ? typed_rep : rep)};
  endtask

  // result receiver and checker
  initial begin
    int unsigned  gap;
    cell_report_t want;
    @(posedge rst_ni);
    forever begin
      gap = sink_calm ? 0 : $urandom_range(0, 16);
      @(negedge clk_i);
      if (gap != 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk_i);
      while (!(result_bus.valid === 1'b1 && result_bus.ready === 1'b1));
      if (pending_cells.size() == 0) begin
        $error("unexpected result row=%0d col=%0d count=%0d done=%0b", result_bus.cell_row,
               result_bus.cell_col, result_bus.point_count, result_bus.scan_done);
        mismatches++;
      end else begin
        want = pending_cells.pop_front();
        if (result_bus.cell_row !== want.row) begin
          $error("cell_row: expected %0d, got %0d", want.row, result_bus.cell_row);
          mismatches++;
        end
        if (result_bus.cell_col !== want.col) begin
          $error("cell_col: expected %0d, got %0d", want.col, result_bus.cell_col);
          mismatches++;
        end
        if (result_bus.point_count !== want.count) begin
          $error("point_count: expected %0d, got %0d", want.count, result_bus.point_count);
          mismatches++;
        end
        if (result_bus.scan_done !== want.done) begin
          $error("scan_done: expected %0b, got %0b", want.done, result_bus.scan_done);
          mismatches++;
        end
      end
    end
  end

  // watchdog: no transfer for too long ends the run
  always @(posedge clk_i) begin
    if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
        (result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    script_row_t  script [$];
    cell_report_t scan_end, origin_one;
    int           w, e, n, s, lon, lat;
    int unsigned  lon_span, lat_span;
    logic [6:0]   wide, high;
    cmd_e         cmd;
    bit           adult;

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = '0;
    cfg_wdata_i         = '0;
    item_bus.valid      = 1'b0;
    item_bus.command    = CMD_ADD;
    item_bus.is_adult   = 1'b0;
    item_bus.point_lon  = '0;
    item_bus.point_lat  = '0;
    result_bus.ready    = 1'b0;
    mismatches          = 0;
    quiet_cycles        = 0;
    src_calm            = 1'b0;
    sink_calm           = 1'b0;
    scan_ptr            = 0;
    m_west  = 0; m_east  = 0; m_north = 0; m_south = 0;
    m_wide  = 7'd1;
    m_high  = 7'd1;
    foreach (tally[i]) tally[i] = '0;

    scan_end   = '{row: '0, col: '0, count: '0, done: 1'b1};
    origin_one = '{row: '0, col: '0, count: 32'd1, done: 1'b0};

    // reset grid: 1x1, zero spans
    script = {script, point_row(CMD_READ, 1'b0, 0, 0, 1'b1, scan_end)};
    script = {script, point_row(CMD_ADD, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000)};
    script = {script, point_row(CMD_ADD, 1'b0, 0, 0)};
    script = {script, point_row(CMD_READ, 1'b1, 0, 0, 1'b1, origin_one)};
    script = {script, point_row(CMD_READ, 1'b0, 0, 0, 1'b1, scan_end)};
    // full coordinate range, largest grid
    script = {script, reg_row(CFG_WEST, 32'h8000_0000)};
    script = {script, reg_row(CFG_EAST, 32'h7FFF_FFFF)};
    script = {script, reg_row(CFG_NORTH, 32'h7FFF_FFFF)};
    script = {script, reg_row(CFG_SOUTH, 32'h8000_0000)};
    script = {script, reg_row(CFG_WIDE, 32'd64)};
    script = {script, reg_row(CFG_HIGH, 32'd64)};
    script = {script, point_row(CMD_ADD, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF)};
    script = {script, point_row(CMD_ADD, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000)};
    script = {script, point_row(CMD_ADD, 1'b1, 0, 0)};
    script = {script, point_row(CMD_ADD, 1'b1, 0, 0)};
    script = {script, point_row(CMD_READ, 1'b0, 0, 0, 1'b1, origin_one)};
    script = {script, point_row(CMD_READ, 1'b0, 0, 0)};
    // zero and oversize cell counts, reversed lon span, zero lat span
    script = {script, reg_row(CFG_WIDE, 32'd0)};
    script = {script, reg_row(CFG_HIGH, 32'd127)};
    script = {script, reg_row(CFG_WEST, 32'h1000_0000)};
    script = {script, reg_row(CFG_EAST, 32'hF000_0000)};
    script = {script, reg_row(CFG_NORTH, 32'h0040_0000)};
    script = {script, reg_row(CFG_SOUTH, 32'h0040_0000)};
    script = {script, point_row(CMD_ADD, 1'b1, 0, 32'h1234_5678)};
    script = {script, point_row(CMD_ADD, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000)};
    // small grid, points west, east and south of it; last corner cell stays from the big grid
    script = {script, reg_row(CFG_WEST, 32'h0000_0000)};
    script = {script, reg_row(CFG_EAST, 32'h0300_0000)};
    script = {script, reg_row(CFG_NORTH, 32'h0100_0000)};
    script = {script, reg_row(CFG_SOUTH, 32'hFF00_0000)};
    script = {script, reg_row(CFG_WIDE, 32'd3)};
    script = {script, reg_row(CFG_HIGH, 32'd5)};
    script = {script, point_row(CMD_ADD, 1'b1, 32'hFFFF_FFFF, 0)};
    script = {script, point_row(CMD_ADD, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000)};
    script = {script, point_row(CMD_ADD, 1'b1, 32'h0180_0000, 0)};
    script = {script, point_row(CMD_READ, 1'b0, 0, 0)};
    // add behind the cursor, then read through wrap and rewind
    script = {script, point_row(CMD_ADD, 1'b1, 0, 32'h7FFF_FFFF)};
    repeat (6) script = {script, point_row(CMD_READ, 1'b0, 0, 0)};

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[r]) begin
      if (script[r].kind == ROW_REG)
        write_reg(script[r].reg_idx, script[r].reg_val);
      else
        send_point(script[r].cmd, script[r].adult, script[r].lon, script[r].lat,
                   script[r].typed, script[r].rep);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      lon_span = 0;
      lat_span = 0;
      if (phase == 0) begin
        w = 32'h8000_0000; e = 32'h7FFF_FFFF; n = 32'h7FFF_FFFF; s = 32'h8000_0000;
        wide = 7'd64;
        high = 7'd64;
      end else if (phase == 1) begin
        w = 32'h7FFF_FFFF; e = 32'h8000_0000; n = 32'h8000_0000; s = 32'h7FFF_FFFF;
        wide = 7'd127;
        high = 7'd0;
      end else begin
        if ($urandom_range(0, 7) != 0) lon_span = $urandom_range(1, 32'h0FFF_FFFF);
        if ($urandom_range(0, 7) != 0) lat_span = $urandom_range(1, 32'h0FFF_FFFF);
        w = $urandom;
        e = ($urandom_range(0, 7) == 0) ? w - int'(lon_span) : w + int'(lon_span);
        n = $urandom;
        s = ($urandom_range(0, 7) == 0) ? n + int'(lat_span) : n - int'(lat_span);
        wide = 7'($urandom_range(1, 8));
        high = 7'($urandom_range(1, 8));
        if ($urandom_range(0, 4) == 0)
          case ($urandom_range(0, 3))
            0: wide = 7'd0;
            1: wide = 7'd64;
            2: wide = 7'd127;
            default: wide = 7'($urandom_range(9, 63));
          endcase
        if ($urandom_range(0, 4) == 0)
          case ($urandom_range(0, 3))
            0: high = 7'd0;
            1: high = 7'd64;
            2: high = 7'd127;
            default: high = 7'($urandom_range(9, 63));
          endcase
      end
      write_reg(CFG_WEST, w);
      write_reg(CFG_EAST, e);
      write_reg(CFG_NORTH, n);
      write_reg(CFG_SOUTH, s);
      write_reg(CFG_WIDE, {25'd0, wide});
      write_reg(CFG_HIGH, {25'd0, high});
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && phase % 4 == 2) await_drain();
        cmd   = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_ADD;
        adult = ($urandom_range(0, 7) != 0);
        if (lon_span == 0 || $urandom_range(0, 3) == 0)
          lon = $urandom;
        else
          lon = w + int'($urandom_range(0, lon_span + lon_span / 4)) - int'(lon_span / 8);
        if (lat_span == 0 || $urandom_range(0, 3) == 0)
          lat = $urandom;
        else
          lat = n - int'($urandom_range(0, lat_span + lat_span / 4)) + int'(lat_span / 8);
        send_point(cmd, adult, lon, lat);
      end
    end

    await_drain();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
